>>> sv/kvi_pkg.sv
// Package for the keyframe vector interpolator: payload types, codes and widths.
package kvi_pkg;

    localparam int DEF_MAX_KEYS   = 1024;
    localparam int DEF_MAX_JOINTS = 16;

    localparam int NJ_W   = 5;
    localparam int NK_W   = 11;
    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;
    localparam int ALPHA_W = 16;

    localparam logic [1:0] CMD_WR_TIME  = 2'd0;
    localparam logic [1:0] CMD_WR_JOINT = 2'd1;
    localparam logic [1:0] CMD_QUERY    = 2'd2;

    localparam logic REG_NUM_JOINTS = 1'b0;
    localparam logic REG_NUM_KEYS   = 1'b1;

    typedef struct packed {
        logic [1:0]         cmd;
        logic [9:0]         key_index;
        logic [3:0]         joint_slot;
        logic signed [31:0] data_word;
    } kvi_in_t;

    typedef struct packed {
        logic [3:0]         joint_number;
        logic signed [31:0] joint_value;
        logic               last;
    } kvi_out_t;

endpackage

>>> sv/kvi_div.sv
// Restoring divider for the interpolation weight, one quotient bit per cycle.
module kvi_div
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [32:0] num,
    input  logic [32:0] den,
    output logic        done,
    output logic [kvi_pkg::ALPHA_W-1:0] quo
);
    import kvi_pkg::*;

    localparam int CNT_W = $clog2(ALPHA_W + 1);

    logic [33:0]        rem_reg, rem_next;
    logic [32:0]        den_reg;
    logic [ALPHA_W-1:0] quo_reg, quo_next;
    logic [CNT_W-1:0]   cnt_reg;
    logic               busy_reg;
    logic               done_reg;
    logic [33:0]        shifted;

    // remainder stays below the divisor, so the doubled value fits
    always_comb
    begin
        shifted  = {rem_reg[32:0], 1'b0};
        rem_next = shifted;
        quo_next = {quo_reg[ALPHA_W-2:0], 1'b0};
        if (shifted >= {1'b0, den_reg})
        begin
            rem_next = shifted - {1'b0, den_reg};
            quo_next = {quo_reg[ALPHA_W-2:0], 1'b1};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(ALPHA_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= {1'b0, num};
            den_reg <= den;
            quo_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

>>> sv/keyframe_vector_interpolator_unit.sv
// Keyframe vector interpolator top level: key tables, query sequencer and output register.
//
// Write commands are accepted while idle and produce nothing. A query
// fetches the first and last key times, runs the bracket search (up to
// log2 of the key count steps, each a read and a compare), fetches the
// bracketing times, runs the serial weight divide when the time falls
// strictly inside the table and the bracketing times differ, then steps
// each joint through the one shared multiplier (two joint memory reads,
// two multiply-accumulates); a stalled output holds the joint step. The
// block takes no new item until the query's last result is in the output register.
// Table entries are not cleared at reset and must be written before use.
module keyframe_vector_interpolator_unit
#(
    parameter int MAX_KEYS   = kvi_pkg::DEF_MAX_KEYS,
    parameter int MAX_JOINTS = kvi_pkg::DEF_MAX_JOINTS
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  kvi_pkg::kvi_in_t              in_data,
    output logic                          out_valid,
    input  logic                          out_stall,
    output kvi_pkg::kvi_out_t             out_data,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [kvi_pkg::ADDR_W-1:0]    paddr,
    input  logic [kvi_pkg::DATA_W-1:0]    pwdata,
    output logic [kvi_pkg::DATA_W-1:0]    prdata,
    output logic                          pready
);
    import kvi_pkg::*;

    localparam int KW  = $clog2(MAX_KEYS);
    localparam int JAW = (MAX_KEYS * MAX_JOINTS > 1) ? $clog2(MAX_KEYS * MAX_JOINTS) : 1;

    typedef enum logic [11:0] {
        S_IDLE   = 12'b000000000001,
        S_T0     = 12'b000000000010,
        S_TN     = 12'b000000000100,
        S_SEARCH = 12'b000000001000,
        S_CMP    = 12'b000000010000,
        S_TA     = 12'b000000100000,
        S_TB     = 12'b000001000000,
        S_DIV    = 12'b000010000000,
        S_JLO    = 12'b000100000000,
        S_JHI    = 12'b001000000000,
        S_JACC   = 12'b010000000000,
        S_JOUT   = 12'b100000000000
    } state_t;

    // configuration
    logic [NJ_W-1:0] num_joints_reg;
    logic [NK_W-1:0] num_keys_reg;
    logic            cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_joints_reg <= NJ_W'(1);
            num_keys_reg   <= NK_W'(1);
        end
        else if (cfg_wr)
        begin
            case (paddr[2])
                REG_NUM_JOINTS: num_joints_reg <= pwdata[NJ_W-1:0];
                REG_NUM_KEYS:   num_keys_reg   <= pwdata[NK_W-1:0];
                default:        num_joints_reg <= num_joints_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            REG_NUM_JOINTS: prdata = {{(DATA_W-NJ_W){1'b0}}, num_joints_reg};
            REG_NUM_KEYS:   prdata = {{(DATA_W-NK_W){1'b0}}, num_keys_reg};
            default:        prdata = '0;
        endcase
    end

    // saturated counts
    logic [KW-1:0]   last_key;
    logic [NJ_W-1:0] last_joint;

    always_comb
    begin
        if (num_keys_reg == '0)
            last_key = '0;
        else if (int'(num_keys_reg) > MAX_KEYS)
            last_key = KW'(MAX_KEYS - 1);
        else
            last_key = KW'(int'(num_keys_reg) - 1);

        if (num_joints_reg == '0)
            last_joint = '0;
        else if (int'(num_joints_reg) > MAX_JOINTS)
            last_joint = NJ_W'(MAX_JOINTS - 1);
        else
            last_joint = num_joints_reg - 1'b1;
    end

    // sequencer registers
    state_t             state_reg, state_next;
    logic signed [31:0] t_reg, t_next;
    logic signed [31:0] t0_reg, t0_next;
    logic signed [31:0] ta_reg, ta_next;
    logic [KW-1:0]      lo_reg, lo_next;
    logic [KW-1:0]      hi_reg, hi_next;
    logic [ALPHA_W-1:0] alpha_reg, alpha_next;
    logic [NJ_W-1:0]    j_reg, j_next;
    logic signed [49:0] acc_reg, acc_next;
    logic               out_valid_reg, out_valid_next;
    kvi_out_t           out_reg, out_next;

    logic               accept;
    logic [KW-1:0]      t_raddr;
    logic [JAW-1:0]     j_raddr;
    logic signed [31:0] t_rdata_reg;
    logic signed [31:0] j_rdata_reg;
    logic [KW:0]        mid_sum;
    logic [KW-1:0]      mid;
    logic [KW:0]        span;
    logic signed [32:0] diff_t;
    logic signed [32:0] diff_k;
    logic               div_start;
    logic               div_done;
    logic [ALPHA_W-1:0] div_quo;
    logic [ALPHA_W:0]   mul_a;
    logic signed [49:0] product;
    logic               out_free;

    assign accept   = in_valid && !in_stall;
    assign in_stall = (state_reg != S_IDLE);
    assign mid_sum  = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid      = mid_sum[KW:1];
    assign span     = {1'b0, hi_reg} - {1'b0, lo_reg};
    assign diff_t   = {t_reg[31], t_reg} - {ta_reg[31], ta_reg};
    assign diff_k   = {t_rdata_reg[31], t_rdata_reg} - {ta_reg[31], ta_reg};
    assign out_free = !out_valid_reg || !out_stall;

    // shared multiplier: weight of the low key, then of the high key
    assign mul_a   = (state_reg == S_JHI) ? ((ALPHA_W+1)'(1 << ALPHA_W) - {1'b0, alpha_reg})
                                          : {1'b0, alpha_reg};
    assign product = 50'(signed'({1'b0, mul_a}) * j_rdata_reg);

    // key memories
    logic signed [31:0] key_times_mem [MAX_KEYS];
    logic signed [31:0] joint_mem [MAX_KEYS * MAX_JOINTS];
    logic               t_we;
    logic               j_we;
    logic [KW-1:0]      t_waddr;
    logic [JAW-1:0]     j_waddr;

    assign t_we = accept && (in_data.cmd == CMD_WR_TIME) && (int'(in_data.key_index) < MAX_KEYS);
    assign j_we = accept && (in_data.cmd == CMD_WR_JOINT)
                  && (int'(in_data.key_index) < MAX_KEYS)
                  && (int'(in_data.joint_slot) < MAX_JOINTS);
    assign t_waddr = KW'(in_data.key_index);
    assign j_waddr = JAW'(int'(in_data.key_index) * MAX_JOINTS + int'(in_data.joint_slot));

    always_ff @(posedge clk)
    begin
        if (t_we)
            key_times_mem[t_waddr] <= in_data.data_word;
        t_rdata_reg <= key_times_mem[t_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (j_we)
            joint_mem[j_waddr] <= in_data.data_word;
        j_rdata_reg <= joint_mem[j_raddr];
    end

    kvi_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (diff_t),
        .den   (diff_k),
        .done  (div_done),
        .quo   (div_quo)
    );

    always_comb
    begin
        state_next     = state_reg;
        t_next         = t_reg;
        t0_next        = t0_reg;
        ta_next        = ta_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        alpha_next     = alpha_reg;
        j_next         = j_reg;
        acc_next       = acc_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_next       = out_reg;
        t_raddr        = '0;
        j_raddr        = JAW'(int'(lo_reg) * MAX_JOINTS + int'(j_reg));
        div_start      = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept && in_data.cmd == CMD_QUERY)
                begin
                    t_next     = in_data.data_word;
                    state_next = S_T0;
                end
            end
            S_T0:
            begin
                t0_next    = t_rdata_reg;
                t_raddr    = last_key;
                state_next = S_TN;
            end
            S_TN:
            begin
                alpha_next = '0;
                j_next     = '0;
                if (t_rdata_reg <= t0_reg || t_reg < t0_reg)
                begin
                    lo_next    = '0;
                    hi_next    = '0;
                    state_next = S_JLO;
                end
                else if (t_reg >= t_rdata_reg)
                begin
                    lo_next    = last_key;
                    hi_next    = last_key;
                    state_next = S_JLO;
                end
                else
                begin
                    lo_next    = '0;
                    hi_next    = last_key;
                    state_next = S_SEARCH;
                end
            end
            S_SEARCH:
            begin
                if (span > (KW+1)'(1))
                begin
                    t_raddr    = mid;
                    state_next = S_CMP;
                end
                else
                begin
                    t_raddr    = lo_reg;
                    state_next = S_TA;
                end
            end
            S_CMP:
            begin
                if (t_rdata_reg <= t_reg)
                    lo_next = mid;
                else
                    hi_next = mid;
                state_next = S_SEARCH;
            end
            S_TA:
            begin
                ta_next    = t_rdata_reg;
                t_raddr    = hi_reg;
                state_next = S_TB;
            end
            S_TB:
            begin
                if (t_rdata_reg > ta_reg && t_reg >= ta_reg)
                begin
                    div_start  = 1'b1;
                    state_next = S_DIV;
                end
                else
                begin
                    hi_next    = lo_reg;
                    state_next = S_JLO;
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    alpha_next = div_quo;
                    state_next = S_JLO;
                end
            end
            S_JLO:
            begin
                state_next = S_JHI;
            end
            S_JHI:
            begin
                acc_next   = product;
                j_raddr    = JAW'(int'(hi_reg) * MAX_JOINTS + int'(j_reg));
                state_next = S_JACC;
            end
            S_JACC:
            begin
                acc_next   = acc_reg + product;
                state_next = S_JOUT;
            end
            S_JOUT:
            begin
                if (out_free)
                begin
                    out_valid_next        = 1'b1;
                    out_next.joint_number = 4'(j_reg);
                    out_next.joint_value  = acc_reg[47:16];
                    out_next.last         = (j_reg == last_joint);
                    j_next                = j_reg + 1'b1;
                    state_next            = (j_reg == last_joint) ? S_IDLE : S_JLO;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        t_reg     <= t_next;
        t0_reg    <= t0_next;
        ta_reg    <= ta_next;
        lo_reg    <= lo_next;
        hi_reg    <= hi_next;
        alpha_reg <= alpha_next;
        j_reg     <= j_next;
        acc_reg   <= acc_next;
        out_reg   <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

>>> dv/kvi_checker.sv
// Checker for the keyframe interpolator: mirrors the key tables and registers, predicts results.
module kvi_checker
    import kvi_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_stall,
    input  kvi_in_t             in_data,
    input  logic                out_valid,
    input  logic                out_stall,
    input  kvi_out_t            out_data,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [ADDR_W-1:0]   paddr,
    input  logic [DATA_W-1:0]   pwdata,
    input  logic                pready,
    output int                  mismatches,
    output int                  pending
);

    localparam int NUM_KEYS_MAX   = DEF_MAX_KEYS;
    localparam int NUM_JOINTS_MAX = DEF_MAX_JOINTS;

    logic [31:0] key_time_mem [NUM_KEYS_MAX];
    logic [31:0] joint_mem [NUM_KEYS_MAX][NUM_JOINTS_MAX];
    logic [NJ_W-1:0] joints_in_use;
    logic [NK_W-1:0] keys_in_use;
    kvi_out_t joint_results_q [$];

    initial mismatches = 0;
    initial pending = 0;

    task automatic note_mismatch(input string what);
        if (mismatches < 10)
            $display("%0t: %s", $realtime, what);
        mismatches++;
    endtask

    // Expand one query into its per-joint interpolated values.
    function automatic void interpolate_query(input logic signed [31:0] query_time);
        int n;
        int nj;
        int lo;
        int hi;
        int mid;
        longint t;
        longint t0;
        longint tn;
        longint ta;
        longint tb;
        longint alpha;
        longint q0;
        longint q1;
        longint v;
        bit blend;
        kvi_out_t r;
        n = keys_in_use;
        if (n < 1) n = 1;
        if (n > NUM_KEYS_MAX) n = NUM_KEYS_MAX;
        nj = joints_in_use;
        if (nj < 1) nj = 1;
        if (nj > NUM_JOINTS_MAX) nj = NUM_JOINTS_MAX;
        t = query_time;
        t0 = $signed(key_time_mem[0]);
        tn = $signed(key_time_mem[n-1]);
        lo = 0;
        hi = 0;
        blend = 0;
        alpha = 0;
        if (tn <= t0 || t < t0)
            lo = 0;
        else if (t >= tn)
            lo = n - 1;
        else
        begin
            hi = n - 1;
            while (hi - lo > 1)
            begin
                mid = (lo + hi) / 2;
                if ($signed(key_time_mem[mid]) <= t)
                    lo = mid;
                else
                    hi = mid;
            end
            ta = $signed(key_time_mem[lo]);
            tb = $signed(key_time_mem[hi]);
            if (tb > ta && t >= ta)
            begin
                alpha = ((t - ta) * 65536) / (tb - ta);
                if (alpha > 65536) alpha = 65536;
                blend = 1;
            end
        end
        for (int j = 0; j < nj; j++)
        begin
            q0 = $signed(joint_mem[lo][j]);
            if (blend)
            begin
                q1 = $signed(joint_mem[hi][j]);
                v = ((65536 - alpha) * q0 + alpha * q1) >>> 16;
            end
            else
                v = q0;
            r.joint_number = j[3:0];
            r.joint_value  = v[31:0];
            r.last         = (j == nj - 1);
            joint_results_q.insert(joint_results_q.size(), r);
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        kvi_out_t want;
        if (!rst_n)
        begin
            joints_in_use = 1;
            keys_in_use = 1;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                if (paddr == ADDR_W'(4 * REG_NUM_JOINTS))
                    joints_in_use = pwdata[NJ_W-1:0];
                else if (paddr == ADDR_W'(4 * REG_NUM_KEYS))
                    keys_in_use = pwdata[NK_W-1:0];
            end
            if (in_valid && !in_stall)
            begin
                case (in_data.cmd)
                    CMD_WR_TIME:  key_time_mem[in_data.key_index] = in_data.data_word;
                    CMD_WR_JOINT: joint_mem[in_data.key_index][in_data.joint_slot] =
                                      in_data.data_word;
                    CMD_QUERY:    interpolate_query(in_data.data_word);
                    default: ;
                endcase
            end
            if (out_valid && !out_stall)
            begin
                if (joint_results_q.size() == 0)
                    note_mismatch($sformatf("unexpected result joint %0d value %0h last %0b",
                        out_data.joint_number, out_data.joint_value, out_data.last));
                else
                begin
                    want = joint_results_q.pop_front();
                    if (out_data.joint_number !== want.joint_number
                        || out_data.joint_value !== want.joint_value
                        || out_data.last !== want.last)
                        note_mismatch($sformatf(
                            "joint/value/last expected %0d %0h %0b got %0d %0h %0b",
                            want.joint_number, want.joint_value, want.last,
                            out_data.joint_number, out_data.joint_value, out_data.last));
                end
            end
        end
        pending = joint_results_q.size();
    end

endmodule

>>> dv/tb.sv
// Testbench top for the keyframe interpolator: stimulus, idling, verdict.
module tb;
    import kvi_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int DRAIN_CYCLES = 300;
    localparam int LOAD_KEYS = 12;

    logic clk = 0;
    logic rst_n = 0;
    logic in_valid = 0;
    logic in_stall;
    kvi_in_t in_data = '0;
    logic out_valid;
    logic out_stall = 0;
    kvi_out_t out_data;
    logic psel = 0;
    logic penable = 0;
    logic pwrite = 0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [DATA_W-1:0] pwdata = '0;
    logic [DATA_W-1:0] prdata;
    logic pready;

    int mismatches;
    int pending;
    int send_gap_pct = 27;
    int recv_stall_pct = 74;
    bit hold_on = 0;
    bit hold_go = 0;
    int cycles = 0;
    int keys_now = 1;
    logic [31:0] time_shadow [DEF_MAX_KEYS];

    always #2 clk = ~clk;

    keyframe_vector_interpolator_unit DUT (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    kvi_checker u_checker (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .pready(pready),
        .mismatches(mismatches), .pending(pending)
    );

    always @(posedge clk)
        out_stall <= hold_on || ($urandom_range(0, 99) < recv_stall_pct);

    // Long receiver hold-off so the block backs up into its input.
    initial
    begin
        wait (hold_go);
        @(posedge clk);
        hold_on <= 1;
        repeat (400) @(posedge clk);
        hold_on <= 0;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic send(input logic [1:0] cmd, input int key, input int slot,
                        input logic [31:0] word);
        // idle at random before offering the transfer
        while ($urandom_range(0, 99) < send_gap_pct)
        begin
            in_valid <= 0;
            @(posedge clk);
        end
        in_valid <= 1;
        in_data.cmd <= cmd;
        in_data.key_index <= key[9:0];
        in_data.joint_slot <= slot[3:0];
        in_data.data_word <= word;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        if (cmd == CMD_WR_TIME) time_shadow[key] = word;
    endtask

    task automatic reg_write(input logic regsel, input int value);
        psel <= 1;
        penable <= 0;
        pwrite <= 1;
        paddr <= ADDR_W'(4 * regsel);
        pwdata <= value;
        @(posedge clk);
        penable <= 1;
        @(posedge clk);
        psel <= 0;
        penable <= 0;
        pwrite <= 0;
    endtask

    // Quiesce the block, then load a new joints/keys setting.
    task automatic retune(input int joints, input int keys);
        in_valid <= 0;
        @(posedge clk);
        wait (pending == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        reg_write(REG_NUM_JOINTS, joints);
        reg_write(REG_NUM_KEYS, keys);
        keys_now = keys & 12'h7FF;
        if (keys_now < 1) keys_now = 1;
        if (keys_now > DEF_MAX_KEYS) keys_now = DEF_MAX_KEYS;
    endtask

    function automatic logic [31:0] pick_query_time();
        int k;
        k = $urandom_range(0, keys_now - 1);
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return time_shadow[k];
            2: return time_shadow[k] + $urandom_range(0, 1 << 20);
            default: return time_shadow[0] - $urandom_range(0, 1 << 16);
        endcase
    endfunction

    task automatic random_items(input int count);
        int pick;
        int k;
        logic [31:0] w;
        for (int i = 0; i < count; i++)
        begin
            pick = $urandom_range(0, 99);
            k = $urandom_range(0, LOAD_KEYS - 1);
            if (pick < 45)
                send(CMD_QUERY, $urandom_range(0, 1023), $urandom_range(0, 15),
                     pick_query_time());
            else if (pick < 80)
                send(CMD_WR_JOINT, k, $urandom_range(0, 15), $urandom);
            else if (pick < 92)
            begin
                // mostly keep order; now and then scramble a time
                w = ($urandom_range(0, 3) == 0) ? $urandom : time_shadow[k];
                send(CMD_WR_TIME, k, $urandom_range(0, 15), w);
            end
            else
                send(2'd3, k, $urandom_range(0, 15), $urandom);
        end
    endtask

    int joint_sets [6] = '{16, 1, 0, 31, 3, 7};
    int key_sets [6]   = '{12, 2, 0, 7, 3, 11};
    int send_pcts [3]  = '{27, 74, 0};
    int recv_pcts [3]  = '{74, 27, 0};

    initial
    begin
        logic [31:0] t;
        logic [31:0] jv;
        repeat (2) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // Sorted times with a flat start and some equal neighbors.
        t = 32'hE000_0000;
        for (int k = 0; k < LOAD_KEYS; k++)
        begin
            if (k > 2 && $urandom_range(0, 7) != 0)
                t = t + $urandom_range(1, 1 << 20);
            send(CMD_WR_TIME, k, $urandom_range(0, 15), t);
            for (int j = 0; j < DEF_MAX_JOINTS; j++)
            begin
                jv = $urandom;
                if (k == 3 || k == 4)
                    jv = ((j + k) % 2) ? 32'h7FFF_FFFF : 32'h8000_0000;
                send(CMD_WR_JOINT, k, j, jv);
            end
        end

        // Directed: flat span, then edges of a ten key table.
        retune(4, 3);
        send(CMD_QUERY, 0, 0, time_shadow[0]);
        send(CMD_QUERY, 1023, 15, 32'h7FFF_FFFF);
        retune(16, 10);
        send(CMD_QUERY, 0, 0, 32'h8000_0000);
        send(CMD_QUERY, 0, 0, time_shadow[0] - 1);
        send(CMD_QUERY, 0, 0, time_shadow[0]);
        send(CMD_QUERY, 0, 0, time_shadow[3] + 1);
        send(CMD_QUERY, 0, 0, (time_shadow[3] >> 1) + (time_shadow[4] >> 1));
        send(CMD_QUERY, 0, 0, time_shadow[4] - 1);
        send(CMD_QUERY, 0, 0, time_shadow[9] - 1);
        send(CMD_QUERY, 0, 0, time_shadow[9]);
        send(CMD_QUERY, 0, 0, 32'h7FFF_FFFF);
        send(2'd3, 1023, 15, 32'hFFFF_FFFF);
        send(CMD_QUERY, 0, 0, time_shadow[5]);

        // Oversized counts saturate; a low last key time makes the span flat.
        send(CMD_WR_TIME, DEF_MAX_KEYS - 1, 0, 32'h8000_0000);
        retune(31, 2047);
        send(CMD_QUERY, 0, 0, time_shadow[5]);
        send(CMD_QUERY, 0, 0, 32'h7FFF_FFFF);

        for (int s = 0; s < 6; s++)
        begin
            retune(joint_sets[s], key_sets[s]);
            send_gap_pct = send_pcts[s / 2];
            recv_stall_pct = recv_pcts[s / 2];
            if (s == 2) hold_go = 1;
            random_items(40);
        end

        in_valid <= 0;
        @(posedge clk);
        wait (pending == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
